[rtl/gfd_pkg.sv]
package gfd_pkg;

  // Poll length in bytes, which also marks no open frame, and the position width.
  localparam int unsigned POLL_LEN = 9;
  localparam int unsigned POS_W    = 4;

  // Bytes after the first one that are kept for the decode. The last byte is
  // used directly as it arrives.
  localparam int unsigned KEPT_BYTES = 7;

  // Id byte codes.
  localparam logic [7:0] ID_DIGITAL = 8'h41;
  localparam logic [7:0] ID_ANALOG  = 8'h73;

  // Stick encoding.
  localparam logic [7:0] STICK_OFFSET = 8'h80;
  localparam logic [7:0] STICK_FULL   = 8'd127;

  // Widths of the result channel.
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 2;

  // Reported pad mode.
  typedef enum logic [1:0] {
    MODE_DIGITAL = 2'd0,
    MODE_ANALOG  = 2'd1,
    MODE_INVALID = 2'd2
  } mode_t;

  // Bytes of a finished poll that the decoder looks at (frame byte 1 is the id).
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] btn_lo;
    logic [7:0] btn_hi;
    logic [7:0] right_x_raw;
    logic [7:0] right_y_raw;
    logic [7:0] left_x_raw;
    logic [7:0] left_y_raw;
  } frame_t;

  // One accepted input byte as held in the input register.
  typedef struct packed {
    logic       valid;
    logic       start;
    logic [7:0] rx_byte;
  } item_t;

endpackage

[rtl/gfd_in_reg.sv]
module gfd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] rx_byte
  input  logic            in_tuser,   // [0] frame_start
  input  logic            advance,
  output gfd_pkg::item_t  item
);

  logic       valid_r;
  logic       valid_nxt;
  logic       start_r;
  logic [7:0] byte_r;

  // The register can take a new transfer when it is empty or is being drained.
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      start_r <= in_tuser;
      byte_r  <= in_tdata;
    end
  end

  assign item.valid   = valid_r;
  assign item.start   = start_r;
  assign item.rx_byte = byte_r;

endmodule

[rtl/gfd_frame_asm.sv]
module gfd_frame_asm (
  input  logic            clk,
  input  logic            rst_n,
  input  gfd_pkg::item_t  item,
  input  logic            advance,
  output logic            frame_done,
  output gfd_pkg::frame_t frame
);

  localparam logic [gfd_pkg::POS_W-1:0] PosIdle =
    gfd_pkg::POS_W'(gfd_pkg::POLL_LEN);
  localparam logic [gfd_pkg::POS_W-1:0] PosLast =
    gfd_pkg::POS_W'(gfd_pkg::POLL_LEN - 1);
  localparam logic [gfd_pkg::POS_W-1:0] PosKeepMax =
    gfd_pkg::POS_W'(gfd_pkg::KEPT_BYTES);

  logic [gfd_pkg::POS_W-1:0] pos_r;
  logic [gfd_pkg::POS_W-1:0] pos_nxt;
  logic [7:0]                bytes_r [gfd_pkg::KEPT_BYTES];
  logic                      frame_open;
  logic                      wr_en;
  logic [2:0]                wr_idx;

  // A frame is open while the position lies between the first kept byte and the last byte of the poll.
  assign frame_open = (pos_r != '0) && (pos_r < PosIdle);
  assign frame_done = item.valid && !item.start && frame_open && (pos_r == PosLast);
  assign wr_en      = advance && !item.start && frame_open && (pos_r <= PosKeepMax);
  assign wr_idx     = pos_r[2:0] - 3'd1;

  // Position counter: a start byte opens a new frame, each further byte steps it.
  always_comb begin
    pos_nxt = pos_r;
    if (advance) begin
      if (item.start) begin
        pos_nxt = gfd_pkg::POS_W'(1);
      end else if (frame_open) begin
        pos_nxt = pos_r + gfd_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= PosIdle;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Byte store, written at the current position less one.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[wr_idx] <= item.rx_byte;
    end
  end

  // The ninth byte goes straight to the decoder.
  assign frame.id          = bytes_r[0];
  assign frame.btn_lo      = bytes_r[2];
  assign frame.btn_hi      = bytes_r[3];
  assign frame.right_x_raw = bytes_r[4];
  assign frame.right_y_raw = bytes_r[5];
  assign frame.left_x_raw  = bytes_r[6];
  assign frame.left_y_raw  = item.rx_byte;

endmodule

[rtl/gfd_report_dec.sv]
module gfd_report_dec (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  gfd_pkg::frame_t                   frame,
  output logic                              out_space,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gfd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [gfd_pkg::OUT_USER_W-1:0]    out_tuser
);

  logic [7:0]      sticks_r [4];
  logic [7:0]      sticks_nxt [4];
  logic [1:0]      press_r;
  logic [1:0]      press_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [15:0]     buttons_r;
  logic [15:0]     buttons_nxt;
  gfd_pkg::mode_t  mode_r;
  gfd_pkg::mode_t  mode_nxt;
  logic [7:0]      inv_lo;
  logic [7:0]      inv_hi;

  // Axis from a pair of direction buttons: +127, -127 or 0 when both or neither.
  function automatic logic [7:0] axis_from_buttons(input logic plus, input logic minus);
    logic [7:0] axis;
    axis = 8'd0;
    if (plus && !minus) begin
      axis = gfd_pkg::STICK_FULL;
    end else if (minus && !plus) begin
      axis = 8'd0 - gfd_pkg::STICK_FULL;
    end
    return axis;
  endfunction

  assign inv_lo = ~frame.btn_lo;
  assign inv_hi = ~frame.btn_hi;

  // Mode decode and update of the held stick values and clicks.
  always_comb begin
    mode_nxt    = gfd_pkg::MODE_INVALID;
    press_nxt   = press_r;
    buttons_nxt = {inv_hi, inv_lo[7:3], 2'b00, inv_lo[0]};
    for (int i = 0; i < 4; i++) begin
      sticks_nxt[i] = sticks_r[i];
    end
    case (frame.id)
      gfd_pkg::ID_DIGITAL: begin
        mode_nxt      = gfd_pkg::MODE_DIGITAL;
        sticks_nxt[0] = axis_from_buttons(inv_lo[5], inv_lo[7]);
        sticks_nxt[1] = axis_from_buttons(inv_lo[4], inv_lo[6]);
        sticks_nxt[2] = axis_from_buttons(inv_hi[5], inv_hi[7]);
        sticks_nxt[3] = axis_from_buttons(inv_hi[4], inv_hi[6]);
      end
      gfd_pkg::ID_ANALOG: begin
        mode_nxt      = gfd_pkg::MODE_ANALOG;
        press_nxt     = inv_lo[2:1];
        sticks_nxt[0] = frame.left_x_raw - gfd_pkg::STICK_OFFSET;
        sticks_nxt[1] = ~(frame.left_y_raw - gfd_pkg::STICK_OFFSET);
        sticks_nxt[2] = frame.right_x_raw - gfd_pkg::STICK_OFFSET;
        sticks_nxt[3] = ~(frame.right_y_raw - gfd_pkg::STICK_OFFSET);
      end
      default: begin
        mode_nxt = gfd_pkg::MODE_INVALID;
      end
    endcase
  end

  // Result register handshake.
  assign out_space = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      press_r     <= 2'b00;
      for (int i = 0; i < 4; i++) begin
        sticks_r[i] <= 8'd0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        press_r <= press_nxt;
        for (int i = 0; i < 4; i++) begin
          sticks_r[i] <= sticks_nxt[i];
        end
      end
    end
  end

  // Report payload, loaded with the held state as it stands after this poll.
  logic [7:0] rep_sticks_r [4];
  logic [1:0] rep_press_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      mode_r      <= mode_nxt;
      buttons_r   <= buttons_nxt;
      rep_press_r <= press_nxt;
      for (int i = 0; i < 4; i++) begin
        rep_sticks_r[i] <= sticks_nxt[i];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = mode_r;
  assign out_tdata  = {6'd0, rep_sticks_r[3], rep_sticks_r[2], rep_sticks_r[1],
                       rep_sticks_r[0], rep_press_r[1], rep_press_r[0], buttons_r};

endmodule

[rtl/gamepad_frame_decoder_top.sv]
// Gamepad poll decoder. Each input transfer carries one byte of the nine-byte
// poll a pad returns, with in_tuser high on the first byte; after the ninth
// byte one report transfer leaves on the out_ side. Bytes without an open
// frame are dropped, and a new start byte abandons any frame in progress.
// The block takes one byte per cycle unless the input stalls: a byte passes
// an input register, the frame assembler, and the decoder into the report
// register, which drives out_tvalid. Input transfers stall only
// while a report is held unread in the output register.
module gamepad_frame_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic                           in_tuser,   // [0] frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] button_flags, [16] left_stick_press, [17] right_stick_press,
  // [25:18] left_x, [33:26] left_y, [41:34] right_x, [49:42] right_y, rest zero
  output logic [gfd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [gfd_pkg::OUT_USER_W-1:0] out_tuser   // [1:0] pad_mode
);

  gfd_pkg::item_t  item;
  gfd_pkg::frame_t frame;
  logic            advance;
  logic            frame_done;
  logic            out_space;
  logic            fire;

  // A held byte moves on when the report register has room for a possible report.
  assign advance = item.valid && out_space;
  assign fire    = advance && frame_done;

  gfd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .item      (item)
  );

  gfd_frame_asm u_frame_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .advance    (advance),
    .frame_done (frame_done),
    .frame      (frame)
  );

  gfd_report_dec u_report_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .frame      (frame),
    .out_space  (out_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
